### src/sha1s_pkg.sv
// Shared types and constants for the SHA-1 streaming hash.
// No dependencies; imported by every module of the block.
`default_nettype none

package sha1s_pkg;

    // Digest and block geometry
    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;
    localparam int IDX_W        = $clog2(DIGEST_WORDS);
    localparam int FILL_W       = 7;

    localparam logic [FILL_W-1:0] BLOCK_BYTES = 7'd64;
    localparam logic [FILL_W-1:0] PAD_LIMIT   = 7'd56;
    localparam logic [7:0]        PAD_BYTE    = 8'h80;

    // Item queue between front and back; depth is a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [31:0] t_word;
    typedef t_word [DIGEST_WORDS-1:0] t_chain;
    typedef t_word [BLOCK_WORDS-1:0]  t_block;

    localparam t_chain INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    // One queued input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_item;

    // Commands from the sequencer to the round unit
    typedef struct packed {
        logic start;      // load block and chain, run 80 rounds
        logic chain_rst;  // return chain to initial constants
    } t_eng_cmd;

    typedef struct packed {
        logic busy;
    } t_eng_stat;

endpackage

`default_nettype wire

### src/sha1s_front.sv
// Input side: takes words, drops empty ones and queues the rest.
// Depends on sha1s_pkg.
`default_nettype none

module sha1s_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_has_byte,
    input  wire logic             i_end_of_message,
    output logic                  o_q_valid,
    output sha1s_pkg::t_item      o_q_item,
    input  wire logic             i_q_pop
);
    import sha1s_pkg::*;

    t_item               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                push, pop;

    assign o_in_stall = (r_count == QCNT_W'(QDEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd];

    // a word with neither byte nor end marker changes nothing
    assign push = i_in_valid && !o_in_stall && (i_has_byte || i_end_of_message);
    assign pop  = i_q_pop && o_q_valid;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!push && pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{data_byte:      i_data_byte,
                             has_byte:       i_has_byte,
                             end_of_message: i_end_of_message};
        end
    end

endmodule

`default_nettype wire

### src/sha1s_round.sv
// SHA-1 round unit: one round per cycle, schedule in a 16-word shift line,
// chaining words held here. Depends on sha1s_pkg.
`default_nettype none

module sha1s_round (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sha1s_pkg::t_eng_cmd  i_cmd,
    output sha1s_pkg::t_eng_stat      o_stat,
    input  wire sha1s_pkg::t_block    i_block,
    output sha1s_pkg::t_chain         o_chain
);
    import sha1s_pkg::*;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    t_chain      r_chain;
    t_block      r_win;
    t_word       r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_round;
    logic        r_busy, r_add;

    t_word       w_next, f, k, t_sum;
    logic [1:0]  sel;
    t_word       mix;

    assign o_stat.busy = r_busy;
    assign o_chain     = r_chain;

    // round group and function
    always_comb begin
        if (r_round < 7'd20) begin
            sel = 2'd0;
        end else if (r_round < 7'd40) begin
            sel = 2'd1;
        end else if (r_round < 7'd60) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        case (sel)
            2'd0:    f = (r_b & r_c) | (~r_b & r_d);
            2'd2:    f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            default: f = r_b ^ r_c ^ r_d;
        endcase
        k     = ROUND_K[sel];
        t_sum = {r_a[26:0], r_a[31:27]} + f + r_e + k + r_win[0];
    end

    // next schedule word, W[t+16] from W[t+13], W[t+8], W[t+2], W[t]
    assign mix    = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
    assign w_next = {mix[30:0], mix[31]};

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_add   <= 1'b0;
            r_round <= '0;
            r_chain <= INIT_CHAIN;
        end else if (!r_busy) begin
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end
            if (i_cmd.chain_rst) begin
                r_chain <= INIT_CHAIN;
            end
        end else if (r_add) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
            r_add      <= 1'b0;
            r_busy     <= 1'b0;
            r_round    <= '0;
        end else if (r_round == LAST_ROUND) begin
            r_add <= 1'b1;
        end else begin
            r_round <= r_round + 7'd1;
        end
    end

    // working variables and schedule window
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_cmd.start) begin
            r_win <= i_block;
            r_a   <= r_chain[0];
            r_b   <= r_chain[1];
            r_c   <= r_chain[2];
            r_d   <= r_chain[3];
            r_e   <= r_chain[4];
        end else if (r_busy && !r_add) begin
            r_win <= {w_next, r_win[BLOCK_WORDS-1:1]};
            r_e   <= r_d;
            r_d   <= r_c;
            r_c   <= {r_b[1:0], r_b[31:2]};
            r_b   <= r_a;
            r_a   <= t_sum;
        end
    end

endmodule

`default_nettype wire

### src/sha1s_pack.sv
// Back-side sequencer: packs queued bytes into the block buffer, pads,
// starts the round unit and sends out the digest. Depends on sha1s_pkg.
`default_nettype none

module sha1s_pack (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  wire sha1s_pkg::t_item       i_q_item,
    output logic                        o_q_pop,
    output sha1s_pkg::t_eng_cmd         o_eng_cmd,
    input  wire sha1s_pkg::t_eng_stat   i_eng_stat,
    output sha1s_pkg::t_block           o_block,
    input  wire sha1s_pkg::t_chain      i_chain,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [31:0]                 o_digest_word,
    output logic [2:0]                  o_word_index,
    output logic                        o_last_word
);
    import sha1s_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD80 = 6'b000010,
        ST_PADZ  = 6'b000100,
        ST_FIN   = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_OUT   = 6'b100000
    } t_pstate;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGEST_WORDS - 1);

    t_pstate            r_state, n_state;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [63:0]        r_bitlen, n_bitlen;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_block             r_buf;
    logic               r_out_valid;
    t_word              r_out_word;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;

    logic               room, start, slot_free, load_out;
    logic               wr_byte, wr_len;
    logic [7:0]         byte_val;

    assign room      = !r_fill[FILL_W-1];
    assign start     = (r_fill == BLOCK_BYTES) && !i_eng_stat.busy;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_block   = r_buf;

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = 3'(r_out_idx);
    assign o_last_word   = r_out_last;

    // sequencer
    always_comb begin
        n_state             = r_state;
        n_fill              = r_fill;
        n_bitlen            = r_bitlen;
        n_idx               = r_idx;
        o_q_pop             = 1'b0;
        wr_byte             = 1'b0;
        wr_len              = 1'b0;
        byte_val            = 8'd0;
        load_out            = 1'b0;
        o_eng_cmd.start     = start;
        o_eng_cmd.chain_rst = 1'b0;
        if (start) begin
            n_fill = '0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && room) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.has_byte) begin
                        wr_byte  = 1'b1;
                        byte_val = i_q_item.data_byte;
                        n_bitlen = r_bitlen + 64'd8;
                    end
                    if (i_q_item.end_of_message) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                if (room) begin
                    wr_byte  = 1'b1;
                    byte_val = PAD_BYTE;
                    n_state  = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (r_fill == PAD_LIMIT) begin
                    wr_len  = 1'b1;
                    n_fill  = BLOCK_BYTES;
                    n_state = ST_FIN;
                end else if (room) begin
                    wr_byte = 1'b1;
                end
            end
            ST_FIN: begin
                if (start) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (!i_eng_stat.busy) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_idx    = r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        o_eng_cmd.chain_rst = 1'b1;
                        n_bitlen            = '0;
                        n_state             = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (wr_byte) begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_bitlen    <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_bitlen <= n_bitlen;
            r_idx    <= n_idx;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_word <= i_chain[r_idx];
            r_out_idx  <= r_idx;
            r_out_last <= (r_idx == LAST_IDX);
        end
    end

    // block buffer, big-endian byte lanes
    always_ff @(posedge i_clk) begin
        if (wr_byte) begin
            case (r_fill[1:0])
                2'd0:    r_buf[r_fill[5:2]][31:24] <= byte_val;
                2'd1:    r_buf[r_fill[5:2]][23:16] <= byte_val;
                2'd2:    r_buf[r_fill[5:2]][15:8]  <= byte_val;
                default: r_buf[r_fill[5:2]][7:0]   <= byte_val;
            endcase
        end
        if (wr_len) begin
            r_buf[BLOCK_WORDS-2] <= r_bitlen[63:32];
            r_buf[BLOCK_WORDS-1] <= r_bitlen[31:0];
        end
    end

endmodule

`default_nettype wire

### src/sha1_streaming_hash.sv
// Top level of the SHA-1 streaming hash: input queue, sequencer, round unit.
// Depends on sha1s_pkg, sha1s_front, sha1s_pack and sha1s_round.
//
//   channel | direction | handshake                 | payload
//   input   | in        | i_in_valid / o_in_stall   | i_data_byte, i_has_byte, i_end_of_message
//   output  | out       | o_out_valid / i_out_stall | o_digest_word, o_word_index, o_last_word
//
// A word enters the 4-entry queue; the sequencer packs one byte per cycle while the block
// buffer has room and no message end is being closed. Each 64-byte block runs in the round
// unit as 80 rounds and one chain add; the next block fills meanwhile.
// End of message writes the pad bytes (up to 64) and then the length, closing one or two
// blocks; the digest words then go out one per cycle while the output is not stalled.
// Reset is synchronous; no clearing pass. Input stalls only when the queue is full.
`default_nettype none

module sha1_streaming_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_message,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);
    import sha1s_pkg::*;

    logic       q_valid, q_pop;
    t_item      q_item;
    t_eng_cmd   eng_cmd;
    t_eng_stat  eng_stat;
    t_block     block;
    t_chain     chain;

    sha1s_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_q_valid        (q_valid),
        .o_q_item         (q_item),
        .i_q_pop          (q_pop)
    );

    sha1s_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_eng_cmd     (eng_cmd),
        .i_eng_stat    (eng_stat),
        .o_block       (block),
        .i_chain       (chain),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    sha1s_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (eng_cmd),
        .o_stat  (eng_stat),
        .i_block (block),
        .o_chain (chain)
    );

    // round unit is never restarted mid-block
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_cmd.start |-> !eng_stat.busy)
        else $error("round unit started while busy");

    // chain is only reset between blocks
    a_rst_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eng_cmd.chain_rst |-> !eng_stat.busy)
        else $error("chain reset while round unit busy");

    // digest words follow each other without gaps
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_word |=>
            o_out_valid && (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word sequence broken");

endmodule

`default_nettype wire

### dv/sha1_streaming_hash_tb.sv
// Testbench for sha1_streaming_hash: byte-wise messages in, five-word digests out.
// Depends on sha1s_pkg and the RTL under src; digests come from a SHA-1 predictor
// in the scoreboard class, and the words are checked in order as they arrive.
`default_nettype none

module sha1_streaming_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1s_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TOTAL_ITEMS  = 450;
    localparam int DRAIN_CYCLES = 300;

    // SHA-1 round constants
    localparam t_word K_R00 = 32'h5A827999;
    localparam t_word K_R20 = 32'h6ED9EBA1;
    localparam t_word K_R40 = 32'h8F1BBCDC;
    localparam t_word K_R60 = 32'hCA62C1D6;

    typedef struct packed {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    // Predicts digests from accepted input words and checks arriving digest words
    class sha1_scoreboard;
        t_word          chain [5];
        t_word          blk [16];
        int unsigned    fill;
        logic [63:0]    bit_len;
        t_digest_beat   digest_q [$];
        int             errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            chain[0] = 32'h67452301;
            chain[1] = 32'hEFCDAB89;
            chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476;
            chain[4] = 32'hC3D2E1F0;
            fill     = 0;
            bit_len  = '0;
        endfunction

        function int pending();
            return digest_q.size();
        endfunction

        // 80-round compression of blk into chain
        function void compress_block();
            t_word w [80];
            t_word a, b, c, d, e, f, k, t, x;
            for (int r = 0; r < 16; r++) w[r] = blk[r];
            for (int r = 16; r < 80; r++) begin
                x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
                w[r] = {x[30:0], x[31]};
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int r = 0; r < 80; r++) begin
                if (r < 20) begin
                    f = (b & c) | (~b & d);
                    k = K_R00;
                end else if (r < 40) begin
                    f = b ^ c ^ d;
                    k = K_R20;
                end else if (r < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_R40;
                end else begin
                    f = b ^ c ^ d;
                    k = K_R60;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[r];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        // Big-endian byte packing; compress on a full block
        function void put_byte(logic [7:0] value);
            blk[fill >> 2][24 - 8 * (fill & 3) +: 8] = value;
            fill++;
            if (fill == 64) begin
                compress_block();
                fill = 0;
            end
        endfunction

        // Accepted input word: update the message state, queue a digest on end
        function void note_input(logic [7:0] data, logic has, logic eom);
            if (has) begin
                bit_len += 64'd8;
                put_byte(data);
            end
            if (eom) begin
                put_byte(8'h80);
                if (fill > 56) begin
                    while (fill != 0) put_byte(8'h00);
                end
                while (fill < 56) put_byte(8'h00);
                blk[14] = bit_len[63:32];
                blk[15] = bit_len[31:0];
                compress_block();
                for (int i = 0; i < 5; i++)
                    digest_q.push_back('{word: chain[i], index: 3'(i), last: (i == 4)});
                restart();
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("tb: mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(t_word word, logic [2:0] index, logic last);
            t_digest_beat exp_beat;
            if (digest_q.size() == 0) begin
                report_mismatch($sformatf("unexpected digest word %08h index %0d",
                                          word, index));
            end else begin
                exp_beat = digest_q.pop_front();
                if (word !== exp_beat.word)
                    report_mismatch($sformatf("digest_word %08h, expected %08h (index %0d)",
                                              word, exp_beat.word, exp_beat.index));
                if (index !== exp_beat.index)
                    report_mismatch($sformatf("word_index %0d, expected %0d",
                                              index, exp_beat.index));
                if (last !== exp_beat.last)
                    report_mismatch($sformatf("last_word %0b, expected %0b (index %0d)",
                                              last, exp_beat.last, exp_beat.index));
            end
        endtask
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_has_byte       = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        i_out_stall      = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_scoreboard sb = new();
    int  cycle_count   = 0;
    int  items_sent    = 0;
    bit  in_burst      = 1'b0;
    bit  out_burst     = 1'b0;

    sha1_streaming_hash uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Timeout
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Drive one input word after a random gap (none in a burst) and hold it until accepted
    task send_item(logic [7:0] data, logic has, logic eom);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= data;
        i_has_byte       <= has;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(data, has, eom);
        items_sent++;
    endtask

    // Hold off the sender until every queued digest word has come out
    task wait_digests_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random-content message of len bytes, with empty words mixed in
    task send_message(int len);
        logic [7:0] data;
        bit         eom_with_byte;
        eom_with_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            data = 8'($urandom);
            if (eom_with_byte && i == len - 1)
                send_item(data, 1'b1, 1'b1);
            else
                send_item(data, 1'b1, 1'b0);
        end
        if (!eom_with_byte) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Digest sink with random stalls per word, none in an output burst
    initial begin : result_sink
        int hold;
        forever begin
            if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
            hold = out_burst ? 0 : $urandom_range(0, 5);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_result(o_digest_word, o_word_index, o_last_word);
        end
    end

    // Main sequence
    initial begin : stimulus
        int len;
        int pick;
        int boundary_lens [4];
        boundary_lens = '{55, 56, 63, 64};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, "abc", zero byte then bare end, 0xFF with end,
        // empty words ignored ahead of an empty message
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);
        i_in_valid <= 1'b0;
        wait_digests_drained();

        // Padding boundaries: fits, spills into a second block, full blocks
        foreach (boundary_lens[i]) begin
            in_burst = (i % 2 == 0);
            send_message(boundary_lens[i]);
        end

        // Random messages, mostly short, until the item count is reached
        while (items_sent < TOTAL_ITEMS) begin
            in_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(0, 15);
            else if (pick < 92)
                len = $urandom_range(52, 68);
            else
                len = $urandom_range(115, 130);
            send_message(len);
            if ($urandom_range(0, 6) == 0) begin
                i_in_valid <= 1'b0;
                wait_digests_drained();
            end
        end
        i_in_valid <= 1'b0;

        wait_digests_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d digest words never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
